// ===== rtl/core/perspective_project_to_screen_macros.svh =====
// Assertion macros for the perspective projection block.
// Used by the top level; relies on signals named clk and arst_n in the including scope.
`ifndef PERSPECTIVE_PROJECT_TO_SCREEN_MACROS_SVH
`define PERSPECTIVE_PROJECT_TO_SCREEN_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PPS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/pps_pkg.sv =====
// Shared types and constants for the perspective projection block.
// No dependencies; used by the controller, the datapath and the top level.
package pps_pkg;

	// Request kinds.
	localparam logic [1:0] KIND_VIEW  = 2'd0;
	localparam logic [1:0] KIND_PROJ  = 2'd1;
	localparam logic [1:0] KIND_POINT = 2'd2;

	// Configuration register indexes.
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// Clip coordinate codes.
	localparam logic [1:0] CRD_X = 2'd0;
	localparam logic [1:0] CRD_Y = 2'd1;
	localparam logic [1:0] CRD_W = 2'd2;

	// Fixed field widths.
	localparam int COORD_W = 32;
	localparam int SCR_W   = 16;
	localparam int DIM_W   = 14;

	// Product split: the second operand is cut at bit SPLIT into a high and a low part.
	localparam int B_W     = 48;
	localparam int SPLIT   = 24;
	localparam int PROD_W  = 56;
	localparam int ACC_W   = 64;
	localparam int TERM_W  = 62;
	localparam int QUO_W   = 17;

	localparam logic signed [ACC_W-1:0] TERM_LIMIT = 64'sh1000_0000_0000_0000;

	localparam logic [DIM_W-1:0] WIDTH_RST  = 14'd1920;
	localparam logic [DIM_W-1:0] HEIGHT_RST = 14'd1080;

	localparam logic signed [SCR_W-1:0] SCR_MAX = 16'sh7fff;
	localparam logic signed [SCR_W-1:0] SCR_MIN = 16'sh8000;
	localparam logic [QUO_W-1:0] QUO_POS_LIM = 17'h07fff;
	localparam logic [QUO_W-1:0] QUO_NEG_LIM = 17'h08000;

	typedef struct packed {
		logic [1:0]                kind;
		logic [3:0]                entry_index;
		logic signed [COORD_W-1:0] entry_value;
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic signed [COORD_W-1:0] point_z;
	} in_item_t;

	typedef struct packed {
		logic                    visible;
		logic signed [SCR_W-1:0] screen_x;
		logic signed [SCR_W-1:0] screen_y;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_TERM,
		ST_ACC,
		ST_NUM,
		ST_DINIT,
		ST_DSTEP,
		ST_DEND,
		ST_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       start;
		logic       mul;
		logic [1:0] row;
		logic [1:0] col;
		logic [1:0] k;
		logic       clip;
		logic       term;
		logic       ent_first;
		logic       ent_add;
		logic       clip_init;
		logic       clip_add;
		logic       coord_store;
		logic [1:0] coord_sel;
		logic       num_calc;
		logic       div_y;
		logic       div_init;
		logic       div_step;
		logic       div_end;
		logic       out_load;
	} cmd_t;

endpackage

// ===== rtl/core/pps_controller.sv =====
// Sequencer for the perspective projection block.
// Depends on pps_pkg; drives the datapath through pps_pkg::cmd_t.
module pps_controller (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [1:0]        in_kind,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output pps_pkg::cmd_t     cmd
);

	localparam int STEP_W = $clog2(pps_pkg::QUO_W);

	pps_pkg::state_t state_q, state_d;
	logic [1:0]        col_q;
	logic [1:0]        row_q;
	logic [2:0]        k_q;
	logic [STEP_W-1:0] step_q;
	logic              div_y_q;
	logic              out_valid_q;
	logic              clip_prod;
	logic              last_step;
	logic              out_free;

	assign clip_prod = k_q[2];
	assign last_step = (step_q == STEP_W'(pps_pkg::QUO_W - 1));
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == pps_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pps_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		// Row order 0 is matrix row 3 (the constant w term), then rows 0 to 2.
		cmd.row       = (row_q == 2'd0) ? 2'd3 : row_q - 2'd1;
		cmd.col       = (col_q == pps_pkg::CRD_W) ? 2'd3 : col_q;
		cmd.k         = k_q[1:0];
		cmd.clip      = clip_prod;
		cmd.coord_sel = col_q;
		cmd.div_y     = div_y_q;
		case (state_q)
			pps_pkg::ST_IDLE: begin
				if (in_valid && in_kind == pps_pkg::KIND_POINT) begin
					cmd.start = 1'b1;
					state_d   = pps_pkg::ST_MUL;
				end
			end
			pps_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = pps_pkg::ST_TERM;
			end
			pps_pkg::ST_TERM: begin
				cmd.term = 1'b1;
				state_d  = pps_pkg::ST_ACC;
			end
			pps_pkg::ST_ACC: begin
				state_d = pps_pkg::ST_MUL;
				if (!clip_prod) begin
					cmd.ent_add   = 1'b1;
					cmd.ent_first = (k_q == 3'd0);
					cmd.clip_init = (k_q == 3'd3) && (row_q == 2'd0);
				end else begin
					cmd.clip_add = 1'b1;
					if (row_q == 2'd3) begin
						cmd.coord_store = 1'b1;
						if (col_q == pps_pkg::CRD_W) begin
							state_d = pps_pkg::ST_NUM;
						end
					end
				end
			end
			pps_pkg::ST_NUM: begin
				cmd.num_calc = 1'b1;
				state_d      = pps_pkg::ST_DINIT;
			end
			pps_pkg::ST_DINIT: begin
				cmd.div_init = 1'b1;
				state_d      = pps_pkg::ST_DSTEP;
			end
			pps_pkg::ST_DSTEP: begin
				cmd.div_step = 1'b1;
				if (last_step) begin
					state_d = pps_pkg::ST_DEND;
				end
			end
			pps_pkg::ST_DEND: begin
				cmd.div_end = 1'b1;
				state_d     = div_y_q ? pps_pkg::ST_DONE : pps_pkg::ST_NUM;
			end
			pps_pkg::ST_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = pps_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pps_pkg::ST_IDLE;
			end
		endcase
	end

	// Product, row, column and divide step counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			k_q     <= '0;
			step_q  <= '0;
			div_y_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				col_q   <= '0;
				row_q   <= '0;
				k_q     <= '0;
				div_y_q <= 1'b0;
			end
			if (cmd.ent_add) begin
				if (k_q == 3'd3) begin
					if (row_q == 2'd0) begin
						row_q <= 2'd1;
						k_q   <= '0;
					end else begin
						k_q <= 3'd4;
					end
				end else begin
					k_q <= k_q + 3'd1;
				end
			end
			if (cmd.clip_add) begin
				k_q <= '0;
				if (row_q == 2'd3) begin
					row_q <= '0;
					col_q <= col_q + 2'd1;
				end else begin
					row_q <= row_q + 2'd1;
				end
			end
			if (cmd.div_init) begin
				step_q <= '0;
			end else if (cmd.div_step) begin
				step_q <= step_q + STEP_W'(1);
			end
			if (cmd.div_end) begin
				div_y_q <= 1'b1;
			end
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== rtl/core/pps_datapath.sv =====
// Datapath of the perspective projection block: matrices, shared multiplier,
// accumulators, screen divider and result register. Depends on pps_pkg.
module pps_datapath #(
	parameter int FRAC_BITS  = 16,
	parameter int WORD_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_accept,
	input  pps_pkg::in_item_t            in_item,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [pps_pkg::DIM_W-1:0]    cfg_data,
	input  pps_pkg::cmd_t                cmd,
	output pps_pkg::out_item_t           out_item
);

	localparam int UP    = pps_pkg::SPLIT - FRAC_BITS;
	localparam int SUM_W = WORD_WIDTH + 1;
	localparam int NUM_W = WORD_WIDTH + 16;
	localparam int DIV_W = WORD_WIDTH + 18;
	localparam int CW    = pps_pkg::COORD_W;
	localparam logic signed [pps_pkg::ACC_W-1:0] WMAX =
		(64'sd1 <<< (WORD_WIDTH - 1)) - 64'sd1;
	localparam logic signed [pps_pkg::ACC_W-1:0] WMIN = -WMAX - 64'sd1;
	localparam logic signed [pps_pkg::ACC_W-1:0] LIM = pps_pkg::TERM_LIMIT >>> UP;

	// Saturate an exact sum to the combined-word range.
	function automatic logic signed [WORD_WIDTH-1:0] sat_word(
		input logic signed [pps_pkg::ACC_W-1:0] v);
		logic signed [WORD_WIDTH-1:0] r;
		if (v > WMAX) begin
			r = WMAX[WORD_WIDTH-1:0];
		end else if (v < WMIN) begin
			r = WMIN[WORD_WIDTH-1:0];
		end else begin
			r = v[WORD_WIDTH-1:0];
		end
		return r;
	endfunction

	logic [CW-1:0]                       view_q [16];
	logic [CW-1:0]                       proj_q [16];
	logic [pps_pkg::DIM_W-1:0]           width_q, height_q;
	logic signed [CW-1:0]                px_q, py_q, pz_q;
	logic signed [CW-1:0]                a_op;
	logic signed [pps_pkg::B_W-1:0]      b_op;
	logic signed [pps_pkg::B_W-pps_pkg::SPLIT-1:0] hi_part;
	logic signed [pps_pkg::SPLIT:0]      lo_part;
	logic signed [pps_pkg::PROD_W-1:0]   hi_prod;
	logic signed [pps_pkg::PROD_W:0]     lo_prod;
	logic signed [pps_pkg::PROD_W-1:0]   hi_s1, lo_s1;
	logic signed [pps_pkg::ACC_W-1:0]    hi_ext, lo_ext, term_full, term_c;
	logic signed [pps_pkg::TERM_W-1:0]   term_s2;
	logic signed [pps_pkg::ACC_W-1:0]    term_ext;
	logic signed [pps_pkg::ACC_W-1:0]    ent_acc_q, clip_acc_q, ent_sum, clip_sum;
	logic signed [WORD_WIDTH-1:0]        sat_ent;
	logic signed [WORD_WIDTH-1:0]        cx_q, cy_q, cw_q;
	logic signed [SUM_W-1:0]             num_sum;
	logic signed [pps_pkg::DIM_W:0]      dim_s;
	logic signed [NUM_W-1:0]             num_prod, num_s1;
	logic [NUM_W-1:0]                    mag;
	logic [DIV_W-1:0]                    dext, rem_q, dvs_q;
	logic [pps_pkg::QUO_W-1:0]           quo_q, quo_neg;
	logic                                neg_q, nz_q, big_q;
	logic signed [pps_pkg::SCR_W-1:0]    scr_c, sx_q, sy_q;
	pps_pkg::out_item_t                  out_q;

	// Matrix entries, written by load requests.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				view_q[i] <= '0;
				proj_q[i] <= '0;
			end
		end else if (in_accept) begin
			if (in_item.kind == pps_pkg::KIND_VIEW) begin
				view_q[in_item.entry_index] <= in_item.entry_value;
			end else if (in_item.kind == pps_pkg::KIND_PROJ) begin
				proj_q[in_item.entry_index] <= in_item.entry_value;
			end
		end
	end

	// Viewport registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= pps_pkg::WIDTH_RST;
			height_q <= pps_pkg::HEIGHT_RST;
		end else if (cfg_we) begin
			if (cfg_index == pps_pkg::REG_WIDTH) begin
				width_q <= cfg_data;
			end else begin
				height_q <= cfg_data;
			end
		end
	end

	// Point capture.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			px_q <= in_item.point_x;
			py_q <= in_item.point_y;
			pz_q <= in_item.point_z;
		end
	end

	// Operand selection: a view entry times a projection entry, or a point
	// coordinate times a finished combined entry.
	assign sat_ent = sat_word(ent_acc_q);
	always_comb begin
		if (cmd.clip) begin
			case (cmd.row)
				2'd0:    a_op = px_q;
				2'd1:    a_op = py_q;
				default: a_op = pz_q;
			endcase
			b_op = pps_pkg::B_W'(sat_ent);
		end else begin
			a_op = $signed(view_q[{cmd.row, cmd.k}]);
			b_op = pps_pkg::B_W'($signed(proj_q[{cmd.k, cmd.col}]));
		end
	end

	// Split multiply; both halves are registered.
	assign hi_part = b_op[pps_pkg::B_W-1:pps_pkg::SPLIT];
	assign lo_part = $signed({1'b0, b_op[pps_pkg::SPLIT-1:0]});
	assign hi_prod = a_op * hi_part;
	assign lo_prod = a_op * lo_part;

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			hi_s1 <= hi_prod;
			lo_s1 <= lo_prod[pps_pkg::PROD_W-1:0];
		end
	end

	// Scale by the fraction bits (floor) and clamp the term.
	assign hi_ext    = pps_pkg::ACC_W'(hi_s1);
	assign lo_ext    = pps_pkg::ACC_W'(lo_s1);
	assign term_full = (hi_ext <<< UP) + (lo_ext >>> FRAC_BITS);
	always_comb begin
		if (hi_ext > LIM) begin
			term_c = pps_pkg::TERM_LIMIT;
		end else if (hi_ext < -LIM) begin
			term_c = -pps_pkg::TERM_LIMIT;
		end else if (term_full > pps_pkg::TERM_LIMIT) begin
			term_c = pps_pkg::TERM_LIMIT;
		end else if (term_full < -pps_pkg::TERM_LIMIT) begin
			term_c = -pps_pkg::TERM_LIMIT;
		end else begin
			term_c = term_full;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.term) begin
			term_s2 <= term_c[pps_pkg::TERM_W-1:0];
		end
	end

	// Accumulators for the combined entry and the clip coordinate.
	assign term_ext = pps_pkg::ACC_W'(term_s2);
	assign ent_sum  = (cmd.ent_first ? '0 : ent_acc_q) + term_ext;
	assign clip_sum = clip_acc_q + term_ext;

	always_ff @(posedge clk) begin
		if (cmd.ent_add) begin
			ent_acc_q <= ent_sum;
		end
		if (cmd.clip_init) begin
			clip_acc_q <= pps_pkg::ACC_W'(sat_word(ent_sum));
		end else if (cmd.clip_add) begin
			clip_acc_q <= clip_sum;
		end
		if (cmd.coord_store) begin
			case (cmd.coord_sel)
				pps_pkg::CRD_X: cx_q <= sat_word(clip_sum);
				pps_pkg::CRD_Y: cy_q <= sat_word(clip_sum);
				default:        cw_q <= sat_word(clip_sum);
			endcase
		end
	end

	// Screen numerator: (x + w) * width or (w - y) * height.
	assign num_sum  = cmd.div_y ? (SUM_W'(cw_q) - SUM_W'(cy_q))
	                            : (SUM_W'(cx_q) + SUM_W'(cw_q));
	assign dim_s    = $signed({1'b0, (cmd.div_y ? height_q : width_q)});
	assign num_prod = num_sum * dim_s;

	always_ff @(posedge clk) begin
		if (cmd.num_calc) begin
			num_s1 <= num_prod;
		end
	end

	// Restoring divide of the magnitude by 2w, one quotient bit a cycle.
	assign mag  = num_s1[NUM_W-1] ? NUM_W'(-num_s1) : NUM_W'(num_s1);
	assign dext = DIV_W'({cw_q, 1'b0});

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q <= DIV_W'(mag);
			dvs_q <= dext << (pps_pkg::QUO_W - 1);
			quo_q <= '0;
			neg_q <= num_s1[NUM_W-1];
			nz_q  <= (num_s1 != '0);
			big_q <= (DIV_W'(mag) >= (dext << pps_pkg::QUO_W));
		end else if (cmd.div_step) begin
			if (rem_q >= dvs_q) begin
				rem_q <= rem_q - dvs_q;
				quo_q <= {quo_q[pps_pkg::QUO_W-2:0], 1'b1};
			end else begin
				quo_q <= {quo_q[pps_pkg::QUO_W-2:0], 1'b0};
			end
			dvs_q <= dvs_q >> 1;
		end
	end

	// Sign, truncation and saturation of the quotient. A zero w always lands
	// in the large case and saturates by the sign of a nonzero numerator, or gives zero.
	assign quo_neg = '0 - quo_q;
	always_comb begin
		if (big_q) begin
			if (!nz_q) begin
				scr_c = '0;
			end else begin
				scr_c = neg_q ? pps_pkg::SCR_MIN : pps_pkg::SCR_MAX;
			end
		end else if (!neg_q) begin
			scr_c = (quo_q > pps_pkg::QUO_POS_LIM) ? pps_pkg::SCR_MAX
			                                        : quo_q[pps_pkg::SCR_W-1:0];
		end else begin
			scr_c = (quo_q > pps_pkg::QUO_NEG_LIM) ? pps_pkg::SCR_MIN
			                                        : quo_neg[pps_pkg::SCR_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_end) begin
			if (cmd.div_y) begin
				sy_q <= scr_c;
			end else begin
				sx_q <= scr_c;
			end
		end
	end

	// Result register; an invisible point reports zero coordinates.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.visible  <= !cw_q[WORD_WIDTH-1];
			out_q.screen_x <= cw_q[WORD_WIDTH-1] ? '0 : sx_q;
			out_q.screen_y <= cw_q[WORD_WIDTH-1] ? '0 : sy_q;
		end
	end

	assign out_item = out_q;

endmodule

// ===== rtl/core/perspective_project_to_screen.sv =====
// Top level of the world-to-screen perspective projection block.
// Depends on pps_pkg, pps_controller, pps_datapath and the macros header.
`include "perspective_project_to_screen_macros.svh"

// Load requests write one entry of the view or projection matrix. A point
// request runs through one shared split multiplier: 57 products (twelve
// combined-matrix entries of four products each, plus nine point products),
// each passing through the multiply, term and accumulate states, then two
// screen divisions (numerator, setup, 17 quotient bits, final sign, truncation
// and saturation). The result then waits in its own register, so the next
// request is accepted while it is still unread.
module perspective_project_to_screen #(
	parameter int FRAC_BITS  = 16,
	parameter int WORD_WIDTH = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  pps_pkg::in_item_t         in_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output pps_pkg::out_item_t        out_data,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [pps_pkg::DIM_W-1:0] cfg_data
);

	pps_pkg::cmd_t cmd;
	logic          in_accept;

	assign in_accept = in_valid && in_ready;

	// Sequencer.
	pps_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_kind   (in_data.kind),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// Arithmetic and storage.
	pps_datapath #(
		.FRAC_BITS  (FRAC_BITS),
		.WORD_WIDTH (WORD_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_accept (in_accept),
		.in_item   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.out_item  (out_data)
	);

	// A point request keeps the block busy in the following cycle.
	`PPS_ASSERT_NEXT(a_point_busy, in_accept && in_data.kind == pps_pkg::KIND_POINT, !in_ready, "point request did not start work")
	// An invisible result carries zero coordinates.
	`PPS_ASSERT_NOW(a_invis_zero, out_valid && !out_data.visible, out_data.screen_x == '0 && out_data.screen_y == '0, "invisible result with nonzero coordinates")
	// A matrix load never produces a result.
	`PPS_ASSERT_NEXT(a_load_silent, in_accept && in_data.kind != pps_pkg::KIND_POINT && !out_valid, !out_valid, "load request produced a result")

endmodule
